/* rtl/core/sorted_priority_queue_top_assert.svh */
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Depth, widths, command and status codes, request and result types.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] item_value;
      logic signed [31:0] item_priority;
   } req_type;

   typedef struct packed {
      logic signed [31:0] head_value;
      logic signed [31:0] head_priority;
      logic               not_empty;
      logic [4:0]         occupancy;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] prio;
   } slot_type;

   typedef struct packed {
      logic ins_en;
      logic rem_en;
      logic occ;
      logic left_ge;
   } cell_ctl_type;

endpackage

/* rtl/core/spq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted row: holds, takes the new entry, or shifts from a
// neighbor, and reports whether it stays ahead of the new entry.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                 clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  spq_pkg::slot_type    new_slot,
   input  spq_pkg::slot_type    left_slot,
   input  spq_pkg::slot_type    right_slot,
   output spq_pkg::slot_type    slot,
   output logic                 ge
);

   spq_pkg::slot_type slot_ff;
   spq_pkg::slot_type slot_in;

   assign ge   = ctl.occ && (slot_ff.prio >= new_slot.prio);
   assign slot = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      priority if (ctl.ins_en) begin
         priority if (ge)          slot_in = slot_ff;
         else if (ctl.left_ge)     slot_in = new_slot;
         else                      slot_in = left_slot;
      end else if (ctl.rem_en) begin
         slot_in = right_slot;
      end else begin
         slot_in = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

/* rtl/core/sorted_priority_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of value/priority pairs kept in descending priority order.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: cmd insert places the pair behind every stored
//   entry of greater or equal priority; cmd remove drops the head entry.
//   rsp_* returns one result per request: head entry after the request,
//   not_empty, occupancy and status (ok, insert dropped on full, remove on
//   empty). An empty queue reports a zero head.
//   The result is registered in the cycle after the request is taken.
//   Throughput: one request per cycle while req_stall is low; every cell compares
//   its priority with the new one in parallel and shifts to or from its neighbor.
//   A single result register decouples the sides: a request is taken while
//   the register is empty or being drained in the same cycle.
//   When the receiver stalls, the result holds and req_stall rises once the
//   register is full.
//   Reset empties the queue and the result register; cell contents are not
//   cleared and are never shown while unoccupied.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_top_assert.svh"

module sorted_priority_queue_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);

   localparam int DEPTH = spq_pkg::QUEUE_DEPTH;
   localparam int CW    = spq_pkg::CNT_W;

   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   spq_pkg::rsp_type  rsp_ff;
   spq_pkg::rsp_type  rsp_in;

   spq_pkg::slot_type slots [DEPTH];
   logic [DEPTH-1:0]  ge;
   spq_pkg::slot_type new_slot;

   logic req_fire;
   logic is_full;
   logic is_empty;
   logic do_ins;
   logic do_rem;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign do_ins    = req_fire && (req_data.cmd == spq_pkg::CMD_INSERT) && !is_full;
   assign do_rem    = req_fire && (req_data.cmd == spq_pkg::CMD_REMOVE) && !is_empty;

   assign new_slot.value = req_data.item_value;
   assign new_slot.prio  = req_data.item_priority;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::cell_ctl_type ctl;
      spq_pkg::slot_type     left_slot;
      spq_pkg::slot_type     right_slot;

      assign ctl.ins_en = do_ins;
      assign ctl.rem_en = do_rem;
      assign ctl.occ    = (CW'(i) < count_ff);

      if (i == 0) begin : g_first
         assign ctl.left_ge = 1'b1;
         assign left_slot   = new_slot;
      end else begin : g_inner
         assign ctl.left_ge = ge[i-1];
         assign left_slot   = slots[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_slot = slots[i];
      end else begin : g_body
         assign right_slot = slots[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .new_slot   (new_slot),
         .left_slot  (left_slot),
         .right_slot (right_slot),
         .slot       (slots[i]),
         .ge         (ge[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      priority if (do_ins) count_in = count_ff + CW'(1);
      else if (do_rem)     count_in = count_ff - CW'(1);
      else                 count_in = count_ff;
   end

   always_comb begin
      rsp_in.head_value    = '0;
      rsp_in.head_priority = '0;
      rsp_in.not_empty     = (count_in != '0);
      rsp_in.occupancy     = 5'(count_in);
      rsp_in.status        = spq_pkg::ST_OK;
      if (req_data.cmd == spq_pkg::CMD_INSERT && is_full) rsp_in.status = spq_pkg::ST_FULL;
      if (req_data.cmd == spq_pkg::CMD_REMOVE && is_empty) rsp_in.status = spq_pkg::ST_EMPTY;
      priority if (do_ins) begin
         if (ge[0]) begin
            rsp_in.head_value    = slots[0].value;
            rsp_in.head_priority = slots[0].prio;
         end else begin
            rsp_in.head_value    = new_slot.value;
            rsp_in.head_priority = new_slot.prio;
         end
      end else if (do_rem) begin
         if (count_in != '0) begin
            rsp_in.head_value    = slots[1].value;
            rsp_in.head_priority = slots[1].prio;
         end
      end else if (!is_empty) begin
         rsp_in.head_value    = slots[0].value;
         rsp_in.head_priority = slots[0].prio;
      end else begin
         rsp_in.head_value    = '0;
         rsp_in.head_priority = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (req_fire)   rsp_valid_in = 1'b1;
      else if (!rsp_stall)     rsp_valid_in = 1'b0;
      else                     rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(DEPTH),
      "fill count beyond queue depth")
   `SPQ_ASSERT_NEXT(a_full_drop, req_fire && req_data.cmd == spq_pkg::CMD_INSERT && is_full,
      $stable(count_ff) && rsp_ff.status == spq_pkg::ST_FULL,
      "insert into full queue changed the count")
   `SPQ_ASSERT_NOW(a_sorted_head, count_ff >= CW'(2), slots[0].prio >= slots[1].prio,
      "head entry out of priority order")
   `SPQ_ASSERT_NEXT(a_result_follows, req_fire, rsp_valid_ff,
      "request taken without a result")

endmodule

/* verif/sorted_priority_queue_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and remove requests through the valid/stall request channel,
// tracks the queue contents in a local sorted list and checks every result
// (head entry, non-empty flag, occupancy, status) in order. The run covers
// empty and full queues, extreme and tied priorities, random request mixes
// under several sender/receiver idling patterns and a long receiver hold-off.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_tb;

   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 4;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   spq_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   spq_pkg::rsp_type rsp_data;

   logic signed [31:0] held_value [spq_pkg::QUEUE_DEPTH];
   logic signed [31:0] held_prio [spq_pkg::QUEUE_DEPTH];
   int                 held_count = 0;
   spq_pkg::rsp_type   expected_heads[$];

   int gap_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   int fail_count = 0;
   int request_count = 0;
   int result_count = 0;
   int full_drops = 0;
   int empty_removes = 0;
   int peak_count = 0;

   sorted_priority_queue_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic spq_pkg::rsp_type apply_to_queue(spq_pkg::req_type r);
      spq_pkg::rsp_type res;
      int               pos;
      res = '0;
      res.status = spq_pkg::ST_OK;
      if (r.cmd == spq_pkg::CMD_INSERT) begin
         if (held_count >= spq_pkg::QUEUE_DEPTH) begin
            res.status = spq_pkg::ST_FULL;
            full_drops++;
         end else begin
            pos = 0;
            while (pos < held_count && held_prio[pos] >= r.item_priority) pos++;
            for (int i = held_count; i > pos; i--) begin
               held_value[i] = held_value[i - 1];
               held_prio[i]  = held_prio[i - 1];
            end
            held_value[pos] = r.item_value;
            held_prio[pos]  = r.item_priority;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            res.status = spq_pkg::ST_EMPTY;
            empty_removes++;
         end else begin
            for (int i = 0; i + 1 < held_count; i++) begin
               held_value[i] = held_value[i + 1];
               held_prio[i]  = held_prio[i + 1];
            end
            held_count--;
         end
      end
      if (held_count > peak_count) peak_count = held_count;
      if (held_count > 0) begin
         res.head_value    = held_value[0];
         res.head_priority = held_prio[0];
         res.not_empty     = 1'b1;
      end
      res.occupancy = 5'(held_count);
      return res;
   endfunction

   function automatic spq_pkg::req_type make_insert(logic signed [31:0] value,
                                                    logic signed [31:0] prio);
      spq_pkg::req_type r;
      r.cmd           = spq_pkg::CMD_INSERT;
      r.item_value    = value;
      r.item_priority = prio;
      return r;
   endfunction

   function automatic spq_pkg::req_type make_random(int insert_pct);
      spq_pkg::req_type r;
      r.cmd = ($urandom_range(99) < insert_pct) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_REMOVE;
      r.item_value = $urandom;
      case ($urandom_range(3))
         0: r.item_priority = $urandom;
         1: r.item_priority = $signed(32'($urandom_range(8))) - 32'sd4;
         2: begin
            case ($urandom_range(3))
               0: r.item_priority = 32'sh7fff_ffff;
               1: r.item_priority = 32'sh8000_0000;
               2: r.item_priority = 32'sd0;
               default: r.item_priority = -32'sd1;
            endcase
         end
         default: r.item_priority = $signed(32'($urandom_range(40))) - 32'sd20;
      endcase
      return r;
   endfunction

   task automatic offer_request(spq_pkg::req_type r);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         req_data  <= make_random(50);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      expected_heads.push_back(apply_to_queue(r));
      request_count++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_heads.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES - 1;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      spq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (expected_heads.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: head %0d/%0d ne %0b occ %0d st %0d",
                        rsp_data.head_value, rsp_data.head_priority,
                        rsp_data.not_empty, rsp_data.occupancy, rsp_data.status);
         end else begin
            want = expected_heads.pop_front();
            if (rsp_data.head_value !== want.head_value ||
                rsp_data.head_priority !== want.head_priority ||
                rsp_data.not_empty !== want.not_empty ||
                rsp_data.occupancy !== want.occupancy ||
                rsp_data.status !== want.status) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch at result %0d", result_count);
                  $display("  expected head %0d/%0d ne %0b occ %0d st %0d",
                           want.head_value, want.head_priority, want.not_empty,
                           want.occupancy, want.status);
                  $display("  actual   head %0d/%0d ne %0b occ %0d st %0d",
                           rsp_data.head_value, rsp_data.head_priority,
                           rsp_data.not_empty, rsp_data.occupancy, rsp_data.status);
               end
            end
         end
      end
   end

   task automatic test_empty_queue();
      spq_pkg::req_type r;
      r = make_random(0);
      offer_request(r);
      offer_request(make_insert(32'sd17, 32'sd3));
      r.item_value    = 32'shffff_ffff;
      r.item_priority = 32'sh7fff_ffff;
      offer_request(r);
      offer_request(r);
   endtask

   task automatic test_ordering_and_ties();
      offer_request(make_insert(32'sh7fff_ffff, 32'sd0));
      offer_request(make_insert(32'sh8000_0000, 32'sh8000_0000));
      offer_request(make_insert(32'sd1, 32'sd5));
      offer_request(make_insert(32'sd2, 32'sd5));
      offer_request(make_insert(32'sd3, 32'sd5));
      offer_request(make_insert(-32'sd1, -32'sd1));
      offer_request(make_insert(32'sd0, 32'sh7fff_ffff));
   endtask

   task automatic test_full_queue();
      while (held_count < spq_pkg::QUEUE_DEPTH)
         offer_request(make_insert($urandom, $urandom));
      offer_request(make_insert(32'sh5555_aaaa, 32'sh7fff_ffff));
      offer_request(make_insert(32'shaaaa_5555, 32'sh8000_0000));
   endtask

   task automatic test_random_mix(int count, int sender_pct, int receiver_pct);
      int done;
      int burst;
      int insert_pct;
      gap_pct   = sender_pct;
      stall_pct = receiver_pct;
      done = 0;
      while (done < count) begin
         burst = $urandom_range(10, 40);
         case ($urandom_range(3))
            0: insert_pct = 15;
            1: insert_pct = 50;
            2: insert_pct = 70;
            default: insert_pct = 95;
         endcase
         repeat (burst) begin
            offer_request(make_random(insert_pct));
            done++;
         end
      end
      wait_for_results();
   endtask

   task automatic test_receiver_hold();
      gap_pct   = 0;
      stall_pct = 0;
      hold_requests++;
      repeat (24) offer_request(make_random(60));
      wait_for_results();
   endtask

   task automatic test_sender_pause();
      gap_pct   = 9;
      stall_pct = 9;
      repeat (10) offer_request(make_random(80));
      wait_for_results();
      repeat (10) offer_request(make_random(30));
      wait_for_results();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_ordering_and_ties();
      test_full_queue();
      wait_for_results();
      test_random_mix(250, 0, 0);
      test_random_mix(250, 62, 0);
      test_random_mix(250, 0, 62);
      test_random_mix(250, 9, 9);
      test_receiver_hold();
      test_sender_pause();
      wait_for_results();
      $display("covered %0d requests, %0d results, %0d full drops, %0d empty removes",
               request_count, result_count, full_drops, empty_removes);
      $display("peak occupancy %0d of %0d, %0d failures",
               peak_count, spq_pkg::QUEUE_DEPTH, fail_count);
      if (fail_count == 0 && expected_heads.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
